// ----- rtl/smcc_pkg.sv -----
// shared types and constants for the sensor min/max calibrate and clamp block
package smcc_pkg;

  localparam int SMP_W            = 10;
  localparam int CH_W             = 3;
  localparam int OP_W             = 2;
  localparam int NUM_CHANNELS_DEF = 6;

  localparam logic [SMP_W-1:0] FULL_SCALE = SMP_W'(1023);

  typedef enum logic [OP_W-1:0] {
    OP_CALIBRATE = 2'd0,
    OP_FINALIZE  = 2'd1,
    OP_CLAMP     = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP_A,
    ST_CMP_B,
    ST_RESP
  } state_t;

  // which operand pair the shared comparator sees
  typedef enum logic [2:0] {
    SEL_CAL_MIN,
    SEL_CAL_MAX,
    SEL_FIN_LOW,
    SEL_FIN_HIGH,
    SEL_CLAMP_LOW,
    SEL_CLAMP_HIGH
  } cmp_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     out_valid;
    logic     cmp_en;
    logic     walk;
    cmp_sel_t sel;
  } ctl_t;

endpackage

// ----- rtl/smcc_in_if.sv -----
// input channel: op, channel and sample with valid/ready
interface smcc_in_if import smcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [CH_W-1:0]  channel;
  logic [SMP_W-1:0] sample;

  modport source (output valid, output op, output channel, output sample, input ready);
  modport sink   (input valid, input op, input channel, input sample, output ready);
endinterface

// ----- rtl/smcc_out_if.sv -----
// result channel: clamped value, channel and thresholds with valid/ready
interface smcc_out_if import smcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] value;
  logic [CH_W-1:0]  channel_out;
  logic [SMP_W-1:0] low_threshold;
  logic [SMP_W-1:0] high_threshold;

  modport source (output valid, output value, output channel_out, output low_threshold,
                  output high_threshold, input ready);
  modport sink   (input valid, input value, input channel_out, input low_threshold,
                  input high_threshold, output ready);
endinterface

// ----- rtl/sensor_minmax_calibrate_clamp.sv -----
// top level: multi-channel min/max calibration and threshold clamp
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        op, channel, sample
//   out_ch   out  valid/ready        value, channel_out, low_threshold, high_threshold
//
// one item at a time: it is taken in the idle state, then two compare steps on the shared
// comparator (two per channel for finalize), then the result is held until taken.
// finalize walks the channel registers through the single comparator.
// synchronous reset restores minima to 1023, maxima to 0 and the thresholds.
// a stalled result keeps in_ch.ready low until its transfer.
module sensor_minmax_calibrate_clamp import smcc_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  smcc_in_if.sink    in_ch,
  smcc_out_if.source out_ch
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  ctl_t             ctl;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] addr;
  logic [SMP_W-1:0] rd_min, rd_max, win;
  logic             take, in_range, hit, accept;

  op_t              op_r;
  logic [CH_W-1:0]  ch_r;
  logic [SMP_W-1:0] val_r, val_nxt;
  logic [SMP_W-1:0] glow_r, glow_nxt;
  logic [SMP_W-1:0] ghigh_r, ghigh_nxt;

  smcc_ctrl #(.NUM_CHANNELS(NUM_CHANNELS), .IDX_W(IDX_W)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .op        (op_r),
    .ctl       (ctl),
    .idx       (idx)
  );

  assign accept   = in_ch.valid && ctl.in_ready;
  assign in_range = (int'(ch_r) < NUM_CHANNELS);
  assign addr     = ctl.walk ? idx : IDX_W'(ch_r);
  assign hit      = ctl.cmp_en && take;

  smcc_store #(.NUM_CHANNELS(NUM_CHANNELS), .IDX_W(IDX_W)) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .addr   (addr),
    .min_we (hit && in_range && ctl.sel == SEL_CAL_MIN),
    .max_we (hit && in_range && ctl.sel == SEL_CAL_MAX),
    .wdata  (win),
    .rd_min (rd_min),
    .rd_max (rd_max)
  );

  smcc_cmp u_cmp (
    .sel    (ctl.sel),
    .work   (val_r),
    .rd_min (rd_min),
    .rd_max (rd_max),
    .glow   (glow_r),
    .ghigh  (ghigh_r),
    .take   (take),
    .win    (win)
  );

  always_comb begin
    val_nxt   = val_r;
    glow_nxt  = glow_r;
    ghigh_nxt = ghigh_r;
    if (accept) begin
      val_nxt = in_ch.sample;
    end else if (hit) begin
      if (ctl.sel == SEL_CLAMP_LOW || ctl.sel == SEL_CLAMP_HIGH) val_nxt = win;
      if (ctl.sel == SEL_FIN_LOW)  glow_nxt  = win;
      if (ctl.sel == SEL_FIN_HIGH) ghigh_nxt = win;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glow_r  <= FULL_SCALE;
      ghigh_r <= '0;
    end else begin
      glow_r  <= glow_nxt;
      ghigh_r <= ghigh_nxt;
    end
  end

  // item payload, loaded on the input transfer; the clamp steps update the value
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (accept) begin
      op_r <= op_t'(in_ch.op);
      ch_r <= in_ch.channel;
    end
  end

  assign in_ch.ready           = ctl.in_ready;
  assign out_ch.valid          = ctl.out_valid;
  assign out_ch.value          = val_r;
  assign out_ch.channel_out    = ch_r;
  assign out_ch.low_threshold  = glow_r;
  assign out_ch.high_threshold = ghigh_r;

endmodule

// ----- rtl/smcc_store.sv -----
// per-channel minimum and maximum registers with one shared address
module smcc_store import smcc_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] addr,
  input  logic             min_we,
  input  logic             max_we,
  input  logic [SMP_W-1:0] wdata,
  output logic [SMP_W-1:0] rd_min,
  output logic [SMP_W-1:0] rd_max
);

  logic [SMP_W-1:0] min_r [NUM_CHANNELS];
  logic [SMP_W-1:0] max_r [NUM_CHANNELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        min_r[i] <= FULL_SCALE;
        max_r[i] <= '0;
      end
    end else begin
      if (min_we) min_r[addr] <= wdata;
      if (max_we) max_r[addr] <= wdata;
    end
  end

  assign rd_min = min_r[addr];
  assign rd_max = max_r[addr];

endmodule

// ----- rtl/smcc_cmp.sv -----
// shared less-than unit with operand selection and winner pick
module smcc_cmp import smcc_pkg::*; (
  input  cmp_sel_t         sel,
  input  logic [SMP_W-1:0] work,
  input  logic [SMP_W-1:0] rd_min,
  input  logic [SMP_W-1:0] rd_max,
  input  logic [SMP_W-1:0] glow,
  input  logic [SMP_W-1:0] ghigh,
  output logic             take,
  output logic [SMP_W-1:0] win
);

  logic [SMP_W-1:0] a;
  logic [SMP_W-1:0] b;
  logic             guard;

  always_comb begin
    guard = 1'b1;
    unique case (sel)
      SEL_CAL_MIN: begin
        a = work; b = rd_min; win = work;
      end
      SEL_CAL_MAX: begin
        a = rd_max; b = work; win = work;
      end
      SEL_FIN_LOW: begin
        // a zero minimum never becomes the low threshold
        a = rd_min; b = glow; win = rd_min; guard = (rd_min != '0);
      end
      SEL_FIN_HIGH: begin
        a = ghigh; b = rd_max; win = rd_max;
      end
      SEL_CLAMP_LOW: begin
        a = work; b = glow; win = glow;
      end
      SEL_CLAMP_HIGH: begin
        a = ghigh; b = work; win = ghigh;
      end
      default: begin
        a = '0; b = '0; win = work; guard = 1'b0;
      end
    endcase
  end

  assign take = guard && (a < b);

endmodule

// ----- rtl/smcc_ctrl.sv -----
// sequencer: two compare steps per item, repeated over channels for finalize
module smcc_ctrl import smcc_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             out_ready,
  input  op_t              op,
  output ctl_t             ctl,
  output logic [IDX_W-1:0] idx
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             walk_last;

  assign walk_last = (idx_r == LAST_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_valid) state_nxt = ST_CMP_A;
      end
      ST_CMP_A: state_nxt = ST_CMP_B;
      ST_CMP_B: begin
        if (op == OP_FINALIZE && !walk_last) begin
          state_nxt = ST_CMP_A;
          idx_nxt   = idx_r + 1'b1;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl.in_ready  = (state_r == ST_IDLE);
    ctl.out_valid = (state_r == ST_RESP);
    ctl.walk      = (op == OP_FINALIZE);
    ctl.cmp_en    = 1'b0;
    ctl.sel       = SEL_CAL_MIN;
    if (state_r == ST_CMP_A || state_r == ST_CMP_B) begin
      unique case (op)
        OP_CALIBRATE: begin
          ctl.cmp_en = 1'b1;
          ctl.sel    = (state_r == ST_CMP_A) ? SEL_CAL_MIN : SEL_CAL_MAX;
        end
        OP_FINALIZE: begin
          ctl.cmp_en = 1'b1;
          ctl.sel    = (state_r == ST_CMP_A) ? SEL_FIN_LOW : SEL_FIN_HIGH;
        end
        OP_CLAMP: begin
          ctl.cmp_en = 1'b1;
          ctl.sel    = (state_r == ST_CMP_A) ? SEL_CLAMP_LOW : SEL_CLAMP_HIGH;
        end
        OP_NONE: ctl.cmp_en = 1'b0;
        default: ctl.cmp_en = 1'b0;
      endcase
    end
  end

  assign idx = idx_r;

endmodule

// ----- verif/tb_sensor_minmax_calibrate_clamp.sv -----
// testbench for the sensor min/max calibrate and clamp block
`timescale 1ns / 1ps

module tb_sensor_minmax_calibrate_clamp import smcc_pkg::*; ();

  localparam int N_CH        = NUM_CHANNELS_DEF;
  localparam int RANDOM_ITEMS = 600;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 2 * N_CH + 8;

  typedef struct packed {
    logic [SMP_W-1:0] value;
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] low;
    logic [SMP_W-1:0] high;
  } sensor_result_t;

  logic clk;
  logic rst_n;

  smcc_in_if  in_ch ();
  smcc_out_if out_ch ();

  sensor_minmax_calibrate_clamp DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // calibration state as the block should hold it
  logic [SMP_W-1:0] ch_min [N_CH];
  logic [SMP_W-1:0] ch_max [N_CH];
  logic [SMP_W-1:0] thr_low;
  logic [SMP_W-1:0] thr_high;

  sensor_result_t queued_readings[$];

  bit idle_on;
  int fail_count;
  int items_sent;
  int readings_seen;
  int op_count [4];
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int draw_wait();
    if (!idle_on) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic clear_calibration();
    for (int i = 0; i < N_CH; i++) begin
      ch_min[i] = FULL_SCALE;
      ch_max[i] = '0;
    end
    thr_low  = FULL_SCALE;
    thr_high = '0;
  endtask

  // folds one item into the calibration state and gives the reading it should produce
  function automatic sensor_result_t apply_sensor_item(op_t op, logic [CH_W-1:0] ch,
                                                       logic [SMP_W-1:0] smp);
    sensor_result_t r;
    logic [SMP_W-1:0] v;
    v = smp;
    case (op)
      OP_CALIBRATE: begin
        if (ch < N_CH) begin
          if (smp < ch_min[ch]) ch_min[ch] = smp;
          if (smp > ch_max[ch]) ch_max[ch] = smp;
        end
      end
      OP_FINALIZE: begin
        for (int i = 0; i < N_CH; i++) begin
          // a zero minimum never becomes the low threshold
          if (ch_min[i] < thr_low && ch_min[i] != '0) thr_low = ch_min[i];
          if (ch_max[i] > thr_high) thr_high = ch_max[i];
        end
      end
      OP_CLAMP: begin
        // low first, then high: crossed thresholds end on the high one
        if (v < thr_low) v = thr_low;
        if (v > thr_high) v = thr_high;
      end
      default: ;
    endcase
    r.value   = v;
    r.channel = ch;
    r.low     = thr_low;
    r.high    = thr_high;
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    fail_count++;
  endtask

  // called at a rising edge; leaves valid high so back-to-back items need no toggle
  task automatic send_item(op_t op, logic [CH_W-1:0] ch, logic [SMP_W-1:0] smp);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.channel <= ch;
    in_ch.sample  <= smp;
    do @(posedge clk); while (!in_ch.ready);
    queued_readings.push_back(apply_sensor_item(op, ch, smp));
    op_count[op]++;
    items_sent++;
  endtask

  // result side: random stall per reading, then check against the oldest expectation
  initial begin
    sensor_result_t want;
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      readings_seen++;
      if (queued_readings.size() == 0) begin
        $display("[%0t] reading transfer with nothing outstanding", $realtime);
        fail_count++;
      end else begin
        want = queued_readings.pop_front();
        if (out_ch.value !== want.value)
          report_mismatch("value", int'(out_ch.value), int'(want.value));
        if (out_ch.channel_out !== want.channel)
          report_mismatch("channel_out", int'(out_ch.channel_out), int'(want.channel));
        if (out_ch.low_threshold !== want.low)
          report_mismatch("low_threshold", int'(out_ch.low_threshold), int'(want.low));
        if (out_ch.high_threshold !== want.high)
          report_mismatch("high_threshold", int'(out_ch.high_threshold), int'(want.high));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles", $realtime, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // thresholds still crossed: every clamp lands on the high threshold
  task automatic test_after_reset();
    send_item(OP_CLAMP, 3'd0, 10'd0);
    send_item(OP_CLAMP, 3'd3, 10'd1023);
    send_item(OP_CLAMP, 3'd7, 10'd512);
    send_item(OP_NONE, 3'd2, 10'd777);
    send_item(OP_FINALIZE, 3'd0, 10'd0);
    send_item(OP_CLAMP, 3'd1, 10'd341);
  endtask

  task automatic test_calibrate_edges();
    send_item(OP_CALIBRATE, 3'd0, 10'd0);     // zero minimum
    send_item(OP_CALIBRATE, 3'd6, 10'd100);   // out of range, no update
    send_item(OP_CALIBRATE, 3'd7, 10'd1023);
    send_item(OP_CALIBRATE, 3'd1, 10'd400);
    send_item(OP_CALIBRATE, 3'd1, 10'd600);
    send_item(OP_CALIBRATE, 3'd2, 10'd450);
  endtask

  task automatic test_finalize_and_clamp();
    send_item(OP_FINALIZE, 3'd4, 10'd3);
    send_item(OP_CLAMP, 3'd0, 10'd0);
    send_item(OP_CLAMP, 3'd5, 10'd1023);
    send_item(OP_CLAMP, 3'd2, 10'd500);
    send_item(OP_CLAMP, 3'd6, 10'd300);
    send_item(OP_NONE, 3'd5, 10'd1023);
    send_item(OP_FINALIZE, 3'd7, 10'd682);
  endtask

  // calibration samples from a window round mid-scale that widens over the run,
  // so the thresholds move gradually and clamps keep hitting both sides
  function automatic logic [SMP_W-1:0] windowed_sample(int progress);
    int half;
    int s;
    half = 8 + (progress * 504) / RANDOM_ITEMS;
    if (half > 511) half = 511;
    s = 512 + $urandom_range(0, 2 * half) - half;
    if (s < 0) s = 0;
    if (s > 1023) s = 1023;
    return s[SMP_W-1:0];
  endfunction

  task automatic test_random_traffic();
    int start;
    int n;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) != 0) begin
        // calibrate burst, finalize, then clamps
        n = $urandom_range(1, 12);
        repeat (n) send_item(OP_CALIBRATE, CH_W'($urandom_range(0, N_CH - 1)),
                             windowed_sample(items_sent - start));
        send_item(OP_FINALIZE, CH_W'($urandom_range(0, 7)),
                  SMP_W'($urandom_range(0, 1023)));
        n = $urandom_range(1, 8);
        repeat (n) send_item(OP_CLAMP, CH_W'($urandom_range(0, 7)),
                             SMP_W'($urandom_range(0, 1023)));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_item(op_t'($urandom_range(0, 3)), CH_W'($urandom_range(0, 7)),
                             SMP_W'($urandom_range(0, 1023)));
      end
    end
  endtask

  task automatic test_full_scale();
    idle_on = 1'b1;
    send_item(OP_CALIBRATE, 3'd5, 10'd1023);
    send_item(OP_CALIBRATE, 3'd4, 10'd1);
    send_item(OP_FINALIZE, 3'd5, 10'd1023);
    send_item(OP_CLAMP, 3'd4, 10'd0);
    send_item(OP_CLAMP, 3'd5, 10'd1023);
    send_item(OP_CLAMP, 3'd3, 10'd1);
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.op      <= OP_NONE;
    in_ch.channel <= '0;
    in_ch.sample  <= '0;
    fail_count    = 0;
    items_sent    = 0;
    readings_seen = 0;
    for (int i = 0; i < 4; i++) op_count[i] = 0;
    clear_calibration();
    idle_on = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    idle_on = 1'b1;
    test_calibrate_edges();
    test_finalize_and_clamp();
    test_random_traffic();
    test_full_scale();

    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (queued_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d items: %0d calibrate, %0d finalize, %0d clamp, %0d unused op",
             items_sent, op_count[OP_CALIBRATE], op_count[OP_FINALIZE],
             op_count[OP_CLAMP], op_count[OP_NONE]);
    $display("%0d readings checked, final thresholds low %0d high %0d",
             readings_seen, thr_low, thr_high);
    if (fail_count == 0 && queued_readings.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/smcc_pkg.sv
rtl/smcc_in_if.sv
rtl/smcc_out_if.sv
rtl/smcc_store.sv
rtl/smcc_cmp.sv
rtl/smcc_ctrl.sv
rtl/sensor_minmax_calibrate_clamp.sv
verif/tb_sensor_minmax_calibrate_clamp.sv
